// ----- rtl/core/u8u16_pkg.sv -----
// Shared types, constants and the byte classifier of the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

    // Default number of words held between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [7:0]  LEAD2_MIN    = 8'hC2;
    localparam logic [15:0] VAL3_MIN     = 16'h0800;
    localparam logic [20:0] VAL4_MIN     = 21'h010000;
    localparam logic [20:0] VAL4_MAX     = 21'h10FFFF;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_INVALID
    } byte_class_t;

    typedef struct packed {
        logic        eos;
        byte_class_t cls;
        logic [7:0]  data;
    } byte_entry_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        if (!b[7]) begin
            c = CLS_ASCII;
        end else if (!b[6]) begin
            c = CLS_CONT;
        end else if (!b[5]) begin
            c = CLS_LEAD2;
        end else if (!b[4]) begin
            c = CLS_LEAD3;
        end else if (!b[3]) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_INVALID;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/utf8_to_utf16_decoder_unit.sv -----
// Top level of the UTF-8 to UTF-16 transcoder with replacement.
// Takes one UTF-8 byte per input word (s_tlast marks the final byte of a string) and
// gives one UTF-16 code unit per output word (m_tlast on the final unit of that string).
// Valid sequences become one unit, or a surrogate pair for values 0x10000..0x10FFFF;
// three-byte surrogate values pass through as they are. A bad lead, an overlong form,
// a value out of range or a missing continuation gives 0xFFFD for the lead byte alone,
// and the bytes after it are decoded again as new leads; a string cut off inside a
// sequence does the same at its end. Every string yields at least one unit.
// Rate: the front takes one byte every cycle while its queue has room, and at most one
// unit leaves every cycle. The front classifies each byte and parks it in a
// QUEUE_DEPTH-word queue; the back holds a four-byte decode window, retires the head
// sequence (a surrogate pair as its high and then its low half) and loads a new byte in
// the same cycle. The back skips one load for each surrogate pair, while the high half
// holds the full window, and after the final byte of a string it loads nothing until
// the window has drained and the last unit of that string has been emitted. The queue
// absorbs these gaps for a while; a long run of four-byte characters or of short
// strings, or a back-pressured output, fills it and drops s_tready. With queue and
// window otherwise empty, the byte completing a sequence goes through the queue, the
// decode window and the output register before m_tvalid rises.
// After reset the block takes words at once; there is no clearing pass.
module utf8_to_utf16_decoder_unit import u8u16_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] in_byte
    input  logic        s_tlast,     // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] code_unit
    output logic        m_tlast      // last_unit
);

    // Queue between the front and the back.
    logic        q_valid;
    byte_entry_t q_entry;
    logic        q_pop;

    u8u16_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop)
    );

    u8u16_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/core/u8u16_front.sv -----
// Front of the transcoder: accept input words, classify each byte, queue it for the back.
module u8u16_front import u8u16_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] in_byte
    input  logic        s_tlast,
    output logic        q_valid,
    output byte_entry_t q_entry,
    input  logic        q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    byte_entry_t      mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;
    logic             pop;

    assign s_tready = (cnt_reg != CNT_FULL);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_entry  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Classify on the way in so the back sees ready-made lead classes.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{eos: s_tlast, cls: classify(s_tdata), data: s_tdata};
        end
    end

endmodule

// ----- rtl/core/u8u16_back.sv -----
// Back of the transcoder: four-byte decode window, sequence checks and output register.
module u8u16_back import u8u16_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  byte_entry_t q_entry,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // [15:0] code_unit
    output logic        m_tlast
);

    localparam int WIN_DEPTH = 4;

    byte_entry_t win_reg [WIN_DEPTH];
    byte_entry_t win_next [WIN_DEPTH];
    logic [2:0]  wcnt_reg, wcnt_next;
    logic        win_eos_reg, win_eos_next;
    logic        pair_reg, pair_next;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_last_reg;

    logic        decided;
    logic [15:0] unit;
    logic [2:0]  consume;
    logic        pair_start;
    logic        emit;
    logic [2:0]  consume_n;
    logic [2:0]  remain;
    logic        load;
    logic        out_free;

    logic        f1_ok, f2_ok, f3_ok;
    logic        p1, p2, p3;
    logic        bad_follow;
    logic [1:0]  need;
    logic [15:0] v2;
    logic [20:0] v4;
    logic [19:0] w4;

    assign p1    = (wcnt_reg >= 3'd2);
    assign p2    = (wcnt_reg >= 3'd3);
    assign p3    = (wcnt_reg == 3'd4);
    assign f1_ok = (win_reg[1].cls == CLS_CONT);
    assign f2_ok = (win_reg[2].cls == CLS_CONT);
    assign f3_ok = (win_reg[3].cls == CLS_CONT);

    assign v2 = {win_reg[0].data[3:0], win_reg[1].data[5:0], win_reg[2].data[5:0]};
    assign v4 = {win_reg[0].data[2:0], win_reg[1].data[5:0], win_reg[2].data[5:0],
                 win_reg[3].data[5:0]};
    assign w4 = 20'(v4 - VAL4_MIN);

    always_comb begin
        case (win_reg[0].cls)
            CLS_LEAD2: need = 2'd1;
            CLS_LEAD3: need = 2'd2;
            CLS_LEAD4: need = 2'd3;
            default:   need = 2'd0;
        endcase
    end

    assign bad_follow = (need >= 2'd1 && p1 && !f1_ok)
                     || (need >= 2'd2 && p2 && !f2_ok)
                     || (need == 2'd3 && p3 && !f3_ok);

    // Decide the head lead: what unit it gives and how many window bytes it uses.
    always_comb begin
        decided    = 1'b1;
        unit       = REPL_UNIT;
        consume    = 3'd1;
        pair_start = 1'b0;
        case (win_reg[0].cls)
            CLS_ASCII: begin
                unit = {8'h00, win_reg[0].data};
            end
            CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                if (bad_follow) begin
                    unit = REPL_UNIT;
                end else if ({1'b0, need} > wcnt_reg - 3'd1) begin
                    // Sequence still short: wait for more bytes unless the string ended.
                    decided = win_eos_reg;
                end else if (win_reg[0].cls == CLS_LEAD2) begin
                    if (win_reg[0].data >= LEAD2_MIN) begin
                        unit    = {5'd0, win_reg[0].data[4:0], win_reg[1].data[5:0]};
                        consume = 3'd2;
                    end
                end else if (win_reg[0].cls == CLS_LEAD3) begin
                    if (v2 >= VAL3_MIN) begin
                        unit    = v2;
                        consume = 3'd3;
                    end
                end else begin
                    if (v4 >= VAL4_MIN && v4 <= VAL4_MAX) begin
                        if (!pair_reg) begin
                            // High half first; hold the window for the low half.
                            unit       = SURR_HI_BASE + {6'd0, w4[19:10]};
                            consume    = 3'd0;
                            pair_start = 1'b1;
                        end else begin
                            unit    = SURR_LO_BASE + {6'd0, w4[9:0]};
                            consume = 3'd4;
                        end
                    end
                end
            end
            default: begin
                unit = REPL_UNIT;
            end
        endcase
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = (wcnt_reg != 3'd0) && decided && out_free;
    assign consume_n = emit ? consume : 3'd0;
    assign remain    = wcnt_reg - consume_n;
    assign load      = q_valid && !win_eos_reg && (remain != 3'd4);
    assign q_pop     = load;

    always_comb begin
        logic [2:0] idx;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            idx = 3'(i) + consume_n;
            win_next[i] = (idx < 3'(WIN_DEPTH)) ? win_reg[idx[1:0]] : win_reg[i];
        end
        if (load) begin
            win_next[remain[1:0]] = q_entry;
        end
    end

    always_comb begin
        wcnt_next    = remain + {2'd0, load};
        win_eos_next = win_eos_reg;
        if (emit && remain == 3'd0) begin
            win_eos_next = 1'b0;
        end
        if (load && q_entry.eos) begin
            win_eos_next = 1'b1;
        end
        pair_next = pair_reg;
        if (emit) begin
            pair_next = pair_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg      <= 3'd0;
            win_eos_reg   <= 1'b0;
            pair_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wcnt_reg    <= wcnt_next;
            win_eos_reg <= win_eos_next;
            pair_reg    <= pair_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (emit) begin
            out_data_reg <= unit;
            out_last_reg <= win_eos_reg && (remain == 3'd0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_wcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wcnt_reg <= 3'd4)
        else $error("decode window count out of range");

    a_pair_window: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_reg |-> (wcnt_reg == 3'd4 && win_reg[0].cls == CLS_LEAD4))
        else $error("low surrogate pending without a full four-byte sequence");

    a_pair_hi_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(pair_reg) |-> (out_valid_reg && out_data_reg[15:10] == SURR_HI_BASE[15:10]))
        else $error("surrogate pair did not start with a high surrogate");

    a_no_load_after_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        win_eos_reg |-> !load)
        else $error("next string loaded before the current one was flushed");

endmodule
